### hw/rtl/mbr_pkg.sv
// Shared constants and types for the MSB-first bitstream reader.
package mbr_pkg;

   localparam int BUF_BYTES  = 4096;
   localparam int BUF_ADDR_W = $clog2(BUF_BYTES);
   localparam int BANKS      = 4;
   localparam int BANK_W     = $clog2(BANKS);
   localparam int ROW_DEPTH  = BUF_BYTES / BANKS;
   localparam int ROW_W      = BUF_ADDR_W - BANK_W;
   localparam int BYTE_W     = 8;
   localparam int CACHE_W    = 32;
   localparam int LEFT_W     = $clog2(CACHE_W) + 1;
   localparam int COUNT_W    = 16;

   typedef enum logic [2:0] {
      KIND_LOAD = 3'd0,
      KIND_SEEK = 3'd1,
      KIND_READ = 3'd2,
      KIND_PEEK = 3'd3,
      KIND_SKIP = 3'd4,
      KIND_BIT  = 3'd5,
      KIND_TRI  = 3'd6
   } kind_type;

endpackage

### hw/rtl/mbr_ram.sv
// Generic simple dual-port RAM with registered read.
module mbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/msb_first_bitstream_reader.sv
// An accepted transaction is registered into the second stage, then into the rsp_* output
// register. One transaction per cycle unless rsp_stall holds the second stage; a tri-state
// code holds off the next one while its bits_left update waits on the fetched cache word.
// A refill reads four byte banks at once. Reset (synchronous, active high) empties the cache
// and zeroes the pointer; the byte store keeps its contents and needs no clearing pass.
module msb_first_bitstream_reader
   import mbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_kind,
   input  logic [BUF_ADDR_W-1:0] req_byte_addr,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic [COUNT_W-1:0]    req_bit_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CACHE_W-1:0]    rsp_value,
   output logic                  rsp_status
);

   // architectural state
   logic [CACHE_W-1:0]    cache_ff;
   logic [CACHE_W-1:0]    cache_in;
   logic [LEFT_W-1:0]     left_ff;
   logic [LEFT_W-1:0]     left_in;
   logic [BUF_ADDR_W-1:0] ptr_ff;
   logic [BUF_ADDR_W-1:0] ptr_in;

   // second stage
   logic                  s1_valid_ff;
   kind_type              s1_kind_ff;
   logic                  s1_err_ff;
   logic                  s1_refill_ff;
   logic [LEFT_W-1:0]     s1_left_ff;
   logic [LEFT_W-1:0]     s1_shift_ff;
   logic [BANK_W-1:0]     s1_lane_ff;

   // output register
   logic                  out_valid_ff;
   logic [CACHE_W-1:0]    out_value_ff;
   logic                  out_status_ff;
   logic [CACHE_W-1:0]    out_value_in;
   logic                  out_status_in;

   logic                  req_accept;
   logic                  s1_move;
   kind_type              req_kind_t;

   // first stage decode
   logic [BUF_ADDR_W-1:0] fetch_addr;
   logic [COUNT_W-1:0]    count;
   logic [COUNT_W-1:0]    remain;
   logic                  count_err;
   logic                  refill;
   logic [LEFT_W-1:0]     shift_amt;
   logic [LEFT_W-1:0]     acc_left_in;
   logic [BUF_ADDR_W-1:0] acc_ptr_in;

   // second stage datapath
   logic [BYTE_W-1:0]     bank_rdata [BANKS];
   logic [CACHE_W-1:0]    word;
   logic [CACHE_W-1:0]    left_mask;
   logic [2*CACHE_W-1:0]  window;
   logic [2*CACHE_W-1:0]  window_sh;
   logic [LEFT_W-2:0]     idx1;
   logic [LEFT_W-2:0]     idx2;
   logic                  tri_b1;
   logic                  tri_b2;
   logic                  tri_refill;
   logic [LEFT_W-1:0]     tri_left;

   assign req_kind_t = kind_type'(req_kind);
   assign s1_move    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   // a tri-state code resolves bits_left only in the second stage
   assign req_stall  = s1_valid_ff && (!s1_move || (s1_kind_ff == KIND_TRI));
   assign req_accept = req_valid && !req_stall;

   // ---------------- first stage: pointer and bit count bookkeeping ----------------
   always_comb begin
      fetch_addr  = ptr_ff;
      acc_ptr_in  = ptr_ff;
      acc_left_in = left_ff;
      refill      = 1'b0;
      remain      = req_bit_count - {{(COUNT_W-LEFT_W){1'b0}}, left_ff};
      count       = (req_kind_t == KIND_BIT) ? COUNT_W'(1) : req_bit_count;
      count_err   = 1'b0;
      shift_amt   = LEFT_W'(CACHE_W) + left_ff - count[LEFT_W-1:0];
      unique case (req_kind_t) inside
         KIND_SEEK: begin
            acc_ptr_in  = req_byte_addr;
            acc_left_in = '0;
         end
         KIND_READ, KIND_PEEK, KIND_BIT: begin
            count_err = (count == '0) || (count > COUNT_W'(CACHE_W));
            if (!count_err) begin
               if (count <= {{(COUNT_W-LEFT_W){1'b0}}, left_ff}) begin
                  if (req_kind_t != KIND_PEEK) begin
                     acc_left_in = left_ff - count[LEFT_W-1:0];
                  end
               end else begin
                  refill = 1'b1;
                  if (req_kind_t != KIND_PEEK) begin
                     acc_ptr_in  = ptr_ff + BUF_ADDR_W'(4);
                     acc_left_in = shift_amt;
                  end
               end
            end
         end
         KIND_SKIP: begin
            if (req_bit_count <= {{(COUNT_W-LEFT_W){1'b0}}, left_ff}) begin
               acc_left_in = left_ff - req_bit_count[LEFT_W-1:0];
            end else begin
               refill      = 1'b1;
               fetch_addr  = ptr_ff + remain[BUF_ADDR_W+2:3];
               acc_ptr_in  = fetch_addr + BUF_ADDR_W'(4);
               acc_left_in = LEFT_W'(CACHE_W) - {{(LEFT_W-3){1'b0}}, remain[2:0]};
            end
         end
         KIND_TRI: begin
            refill = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ---------------- byte store: four banks, one byte lane each ----------------
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [ROW_W-1:0] rd_row;
      logic             wr_en;

      assign rd_row = fetch_addr[BUF_ADDR_W-1:BANK_W]
                      + ROW_W'(BANK_W'(b) < fetch_addr[BANK_W-1:0]);
      assign wr_en  = req_accept && (req_kind_t == KIND_LOAD)
                      && (req_byte_addr[BANK_W-1:0] == BANK_W'(b));

      mbr_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (ROW_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (req_byte_addr[BUF_ADDR_W-1:BANK_W]),
         .wr_data (req_byte_value),
         .rd_en   (req_accept),
         .rd_addr (rd_row),
         .rd_data (bank_rdata[b])
      );
   end

   // ---------------- second stage: extract bits ----------------
   assign word = {bank_rdata[s1_lane_ff],
                  bank_rdata[s1_lane_ff + BANK_W'(1)],
                  bank_rdata[s1_lane_ff + BANK_W'(2)],
                  bank_rdata[s1_lane_ff + BANK_W'(3)]};

   assign left_mask = s1_left_ff[LEFT_W-1] ? '1
                      : ((CACHE_W'(1) << s1_left_ff[LEFT_W-2:0]) - CACHE_W'(1));
   // unread cache bits on top of the fetched word; one shift covers split and plain reads
   assign window    = {cache_ff & left_mask, s1_refill_ff ? word : '0};
   assign window_sh = window >> s1_shift_ff;

   assign idx1 = s1_left_ff[LEFT_W-2:0] - (LEFT_W-1)'(1);
   assign idx2 = s1_left_ff[LEFT_W-2:0] - (LEFT_W-1)'(2);

   always_comb begin
      if (s1_left_ff >= LEFT_W'(2)) begin
         tri_b1     = cache_ff[idx1];
         tri_b2     = cache_ff[idx2];
         tri_refill = 1'b0;
         tri_left   = tri_b1 ? s1_left_ff - LEFT_W'(2) : s1_left_ff - LEFT_W'(1);
      end else if (s1_left_ff == LEFT_W'(1)) begin
         tri_b1     = cache_ff[0];
         tri_b2     = word[CACHE_W-1];
         tri_refill = tri_b1;
         tri_left   = tri_b1 ? LEFT_W'(CACHE_W-1) : '0;
      end else begin
         tri_b1     = word[CACHE_W-1];
         tri_b2     = word[CACHE_W-2];
         tri_refill = 1'b1;
         tri_left   = tri_b1 ? LEFT_W'(CACHE_W-2) : LEFT_W'(CACHE_W-1);
      end
   end

   always_comb begin
      cache_in      = cache_ff;
      out_value_in  = '0;
      out_status_in = 1'b0;
      unique case (s1_kind_ff) inside
         KIND_SEEK: begin
            cache_in = '0;
         end
         KIND_READ, KIND_PEEK, KIND_BIT: begin
            out_status_in = s1_err_ff;
            if (!s1_err_ff) begin
               out_value_in = window_sh[CACHE_W-1:0];
            end
            if (s1_refill_ff && (s1_kind_ff != KIND_PEEK)) begin
               cache_in = word;
            end
         end
         KIND_SKIP: begin
            if (s1_refill_ff) begin
               cache_in = word;
            end
         end
         KIND_TRI: begin
            out_value_in = {{(CACHE_W-2){1'b0}}, tri_b1 & tri_b2, tri_b1 & ~tri_b2};
            if (tri_refill) begin
               cache_in = word;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ptr_in  = ptr_ff;
      left_in = left_ff;
      if (req_accept) begin
         ptr_in  = acc_ptr_in;
         left_in = acc_left_in;
      end else if (s1_move && (s1_kind_ff == KIND_TRI)) begin
         left_in = tri_left;
         if (tri_refill) begin
            ptr_in = ptr_ff + BUF_ADDR_W'(4);
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         left_ff      <= '0;
         cache_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         left_ff <= left_in;
         if (s1_move) begin
            cache_ff <= cache_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff   <= req_kind_t;
         s1_err_ff    <= count_err;
         s1_refill_ff <= refill;
         s1_left_ff   <= left_ff;
         s1_shift_ff  <= shift_amt;
         s1_lane_ff   <= fetch_addr[BANK_W-1:0];
      end
      if (s1_move) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

   // ---------------- checks ----------------
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= LEFT_W'(CACHE_W))
      else $error("bits_left above cache width");

   a_tri_interlock: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_kind_ff == KIND_TRI)) |-> req_stall)
      else $error("transaction accepted behind a tri-state code");

   a_err_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_value == '0))
      else $error("error result carries a value");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> s1_valid_ff)
      else $error("stalled second stage lost its transaction");

endmodule

### dv/mbr_stream_checker.sv
// Checker for the bitstream reader: predicts every result and compares it in order.
`timescale 1ns / 100ps

module mbr_stream_checker
   import mbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [2:0]            req_kind,
   input  logic [BUF_ADDR_W-1:0] req_byte_addr,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic [COUNT_W-1:0]    req_bit_count,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CACHE_W-1:0]    rsp_value,
   input  logic                  rsp_status,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [CACHE_W-1:0] value;
      logic               status;
   } reader_result_type;

   logic [BYTE_W-1:0]     stream_img [BUF_BYTES];
   logic [CACHE_W-1:0]    cache_word;
   int                    cache_left;
   logic [BUF_ADDR_W-1:0] byte_ptr;
   reader_result_type     awaited_results [$];
   int                    misses = 0;

   function automatic logic [CACHE_W-1:0] low_bits(int n);
      return (n >= CACHE_W) ? '1 : ~({CACHE_W{1'b1}} << n);
   endfunction

   // four bytes big-endian, each address wrapping round the ring
   function automatic logic [CACHE_W-1:0] word_at(logic [BUF_ADDR_W-1:0] p);
      return {stream_img[p], stream_img[p + 1'b1], stream_img[p + 2'd2], stream_img[p + 2'd3]};
   endfunction

   task automatic refill_cache();
      cache_word = word_at(byte_ptr);
      byte_ptr   = byte_ptr + 3'd4;
   endtask

   task automatic take_bit(output logic b);
      if (cache_left != 0) begin
         cache_left--;
         b = cache_word[cache_left];
      end else begin
         refill_cache();
         cache_left = CACHE_W - 1;
         b = cache_word[CACHE_W-1];
      end
   endtask

   task automatic extract_bits(input logic [2:0] kind, input logic [BUF_ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] val, input logic [COUNT_W-1:0] cnt,
                               output reader_result_type res);
      int                 n;
      int                 rest;
      int                 second;
      logic [CACHE_W-1:0] first_part;
      logic [CACHE_W-1:0] next_word;
      logic               b0;
      logic               b1;
      n   = cnt;
      res = '0;
      case (kind)
         KIND_LOAD: stream_img[addr] = val;
         KIND_SEEK: begin
            byte_ptr   = addr;
            cache_word = '0;
            cache_left = 0;
         end
         KIND_READ, KIND_PEEK: begin
            if (n == 0 || n > CACHE_W) begin
               res.status = 1'b1;
            end else if (n <= cache_left) begin
               rest      = cache_left - n;
               res.value = (cache_word >> rest) & low_bits(n);
               if (kind == KIND_READ) cache_left = rest;
            end else begin
               // split: the tail of the old cache, then the head of the next word
               first_part = cache_word & low_bits(cache_left);
               second     = n - cache_left;
               if (kind == KIND_READ) begin
                  refill_cache();
                  cache_left = CACHE_W - second;
                  res.value  = (first_part << second) | (cache_word >> cache_left);
               end else begin
                  next_word = word_at(byte_ptr);
                  res.value = (first_part << second) | (next_word >> (CACHE_W - second));
               end
            end
         end
         KIND_SKIP: begin
            if (n <= cache_left) begin
               cache_left -= n;
            end else begin
               rest     = n - cache_left;
               byte_ptr = byte_ptr + BUF_ADDR_W'(rest / BYTE_W);
               refill_cache();
               cache_left = CACHE_W - (rest % BYTE_W);
            end
         end
         KIND_BIT: begin
            take_bit(b0);
            res.value = CACHE_W'(b0);
         end
         KIND_TRI: begin
            take_bit(b0);
            if (b0) begin
               take_bit(b1);
               res.value = CACHE_W'(b1) + 1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      reader_result_type want;
      reader_result_type got;
      reader_result_type fresh;
      if (reset) begin
         cache_word = '0;
         cache_left = 0;
         byte_ptr   = '0;
         awaited_results.delete();
      end else begin
         // results first, so a response can never match the transaction taken at this edge
         if (rsp_valid && !rsp_stall) begin
            got.value  = rsp_value;
            got.status = rsp_status;
            if (awaited_results.size() == 0) begin
               misses++;
               if (misses <= 10)
                  $display("%0t: unexpected result, value %h st %0d", $realtime,
                           got.value, got.status);
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  misses++;
                  if (misses <= 10)
                     $display({"%0t: result mismatch, expected value %h st %0d, ",
                               "got value %h st %0d"},
                              $realtime, want.value, want.status, got.value, got.status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            extract_bits(req_kind, req_byte_addr, req_byte_value, req_bit_count, fresh);
            awaited_results.push_back(fresh);
         end
      end
      fail_count    <= misses;
      pending_count <= awaited_results.size();
   end

endmodule

### dv/tb_msb_first_bitstream_reader.sv
// Testbench top for the bitstream reader: reset, clock, stimulus and verdict.
`timescale 1ns / 100ps

module tb_msb_first_bitstream_reader
   import mbr_pkg::*;
();

   localparam logic [2:0] KIND_SPARE   = 3'd7;
   localparam int         RAND_ITEMS   = 500;
   localparam int         RING_BITS    = BUF_BYTES * BYTE_W;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic [2:0]            req_kind       = KIND_LOAD;
   logic [BUF_ADDR_W-1:0] req_byte_addr  = '0;
   logic [BYTE_W-1:0]     req_byte_value = '0;
   logic [COUNT_W-1:0]    req_bit_count  = '0;
   logic                  rsp_stall      = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [CACHE_W-1:0]    rsp_value;
   logic                  rsp_status;
   int                    fail_count;
   int                    pending_count;

   // what the stimulus knows of the stream: byte image, loaded map, next bit position
   logic [BYTE_W-1:0]     byte_img [BUF_BYTES];
   bit                    loaded   [BUF_BYTES];
   int                    bit_pos = 0;
   int                    sent    = 0;
   bit                    calm    = 1'b0;
   bit                    hold_request = 1'b0;
   int                    win_base;
   int                    win_len;

   logic [BYTE_W-1:0] opening_bytes [12] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80, 8'h01,
                                             8'h7F, 8'hFE, 8'hC3, 8'h3C, 8'h96, 8'h69};

   msb_first_bitstream_reader dut (.*);

   mbr_stream_checker watcher (.*);

   always #6 clock = ~clock;

   // true when every byte the item could fetch has been loaded
   function automatic bit fetch_ok(logic [2:0] kind, int pos, int n);
      int lo;
      int hi;
      case (kind)
         KIND_READ, KIND_PEEK: begin
            if (n < 1 || n > CACHE_W) return 1'b1;
            lo = pos / BYTE_W;
            hi = (pos + n - 1) / BYTE_W + 3;
         end
         KIND_SKIP: begin
            lo = (pos + n) / BYTE_W;
            hi = lo + 3;
         end
         KIND_BIT: begin
            lo = pos / BYTE_W;
            hi = lo + 3;
         end
         KIND_TRI: begin
            lo = pos / BYTE_W;
            hi = (pos + 1) / BYTE_W + 3;
         end
         default: return 1'b1;
      endcase
      for (int i = lo; i <= hi; i++)
         if (!loaded[i % BUF_BYTES]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic send(logic [2:0] kind, int addr, int val, int n);
      logic first_bit;
      if (sent == 350) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (pending_count != 0);
      end
      calm = (sent >= 200 && sent < 320);
      if (sent == 100) hold_request = 1'b1;
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_addr  <= addr[BUF_ADDR_W-1:0];
      req_byte_value <= val[BYTE_W-1:0];
      req_bit_count  <= n[COUNT_W-1:0];
      do @(posedge clock); while (req_stall);
      sent++;
      case (kind)
         KIND_LOAD: begin
            byte_img[addr % BUF_BYTES] = val[BYTE_W-1:0];
            loaded[addr % BUF_BYTES]   = 1'b1;
         end
         KIND_SEEK: bit_pos = (addr % BUF_BYTES) * BYTE_W;
         KIND_READ: if (n >= 1 && n <= CACHE_W) bit_pos = (bit_pos + n) % RING_BITS;
         KIND_SKIP: bit_pos = (bit_pos + n) % RING_BITS;
         KIND_BIT:  bit_pos = (bit_pos + 1) % RING_BITS;
         KIND_TRI: begin
            first_bit = byte_img[bit_pos / BYTE_W][BYTE_W - 1 - bit_pos % BYTE_W];
            bit_pos   = (bit_pos + (first_bit ? 2 : 1)) % RING_BITS;
         end
         default: ;
      endcase
   endtask

   // receiver: random stalls, one long hold-off on request, none while calm
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 12);
         end
      end
   end

   initial begin
      int         pick;
      int         addr;
      int         val;
      int         n;
      int         target;
      int         near;
      logic [2:0] kind;
      bit         live;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 12; i++) send(KIND_LOAD, i, opening_bytes[i], $urandom_range(0, 65535));
      send(KIND_LOAD, 4094, 8'h81, 65535);
      send(KIND_LOAD, 4095, 8'h18, 0);
      send(KIND_READ, $urandom_range(0, 4095), $urandom_range(0, 255), 32);
      send(KIND_PEEK, 4095, 255, 0);
      send(KIND_READ, 0, 0, 65535);
      send(KIND_PEEK, $urandom_range(0, 4095), $urandom_range(0, 255), 32);
      send(KIND_BIT, $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 65535));
      send(KIND_TRI, $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 65535));
      send(KIND_SKIP, $urandom_range(0, 4095), $urandom_range(0, 255), 0);
      send(KIND_READ, $urandom_range(0, 4095), $urandom_range(0, 255), 32);
      send(KIND_SPARE, 4095, 255, 65535);
      send(KIND_SEEK, 4094, $urandom_range(0, 255), $urandom_range(0, 65535));
      send(KIND_READ, $urandom_range(0, 4095), $urandom_range(0, 255), 32);

      while (sent < 25 + RAND_ITEMS) begin
         // load a fresh region of the ring and seek to its start
         win_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 160) : $urandom_range(6, 40);
         win_base = $urandom_range(0, BUF_BYTES - 1);
         for (int i = 0; i < win_len; i++)
            send(KIND_LOAD, (win_base + i) % BUF_BYTES, $urandom_range(0, 255),
                 $urandom_range(0, 65535));
         send(KIND_SEEK, win_base, $urandom_range(0, 255), $urandom_range(0, 65535));
         live = 1'b1;
         while (live && sent < 25 + RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            addr = $urandom_range(0, BUF_BYTES - 1);
            val  = $urandom_range(0, 255);
            n    = $urandom_range(0, 65535);
            if (pick < 44) begin
               kind = (pick < 30) ? KIND_READ : KIND_PEEK;
               n = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 1 : 32)
                                               : $urandom_range(1, 32);
            end else if (pick < 56) begin
               kind = KIND_SKIP;
               case ($urandom_range(0, 3))
                  0: n = $urandom_range(0, 40);
                  1: n = $urandom_range(0, 300);
                  2: begin
                     // land inside the region, going round the whole ring at times
                     target = win_base * BYTE_W + $urandom_range(0, win_len * BYTE_W - 1);
                     n = ((target - bit_pos) & (RING_BITS - 1)) | ($urandom_range(0, 1) << 15);
                  end
                  default: ;
               endcase
            end else if (pick < 71) begin
               kind = KIND_BIT;
            end else if (pick < 84) begin
               kind = KIND_TRI;
            end else if (pick < 89) begin
               kind = KIND_SEEK;
               addr = (win_base + $urandom_range(0, win_len - 1)) % BUF_BYTES;
            end else if (pick < 94) begin
               kind = $urandom_range(0, 1) ? KIND_READ : KIND_PEEK;
               n    = $urandom_range(0, 1) ? 0 : $urandom_range(CACHE_W + 1, 65535);
            end else if (pick < 97) begin
               // stray load, kept clear of the bytes the cache may hold
               kind = KIND_LOAD;
               near = bit_pos / BYTE_W;
               if (((addr - near) & (BUF_BYTES - 1)) < 9 ||
                   ((addr - near) & (BUF_BYTES - 1)) > BUF_BYTES - 5)
                  addr = (near + BUF_BYTES / 2) % BUF_BYTES;
            end else begin
               kind = KIND_SPARE;
            end
            if (fetch_ok(kind, bit_pos, n)) begin
               send(kind, addr, val, n);
            end else if ($urandom_range(0, 1)) begin
               send(KIND_SEEK, (win_base + $urandom_range(0, win_len - 1)) % BUF_BYTES, val, n);
            end else begin
               live = 1'b0;
            end
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2400000;
      $display("status: fail");
      $finish;
   end

endmodule

### sim.f
hw/rtl/mbr_pkg.sv
hw/rtl/mbr_ram.sv
hw/rtl/msb_first_bitstream_reader.sv
dv/mbr_stream_checker.sv
dv/tb_msb_first_bitstream_reader.sv
